FILE: design/sn2d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sn2d_pkg
// Shared types, constants and tables of the 2D simplex noise unit.
// ----------------------------------------------------------------------------
package sn2d_pkg;

  // input format and lattice wrap
  localparam int INPUT_FRAC_BITS = 16;
  localparam int OFS_FRAC        = 24;
  localparam int XS_W            = INPUT_FRAC_BITS + 8;

  // skew / unskew factors
  localparam logic [30:0] SKEW_Q32   = 31'd1572067139;
  localparam logic [29:0] UNSKEW_Q32 = 30'd907633386;
  localparam int          OFS_W      = 27;
  localparam logic signed [OFS_W-1:0] UNSKEW_Q24  = 27'sd3545443;
  localparam logic signed [OFS_W-1:0] UNSKEW2_Q24 = 27'sd7090886;
  localparam logic signed [OFS_W-1:0] ONE_Q24     = 27'sd16777216;

  // corner falloff and output scaling
  localparam logic signed [55:0] HALF_Q48   = 56'sh0000_8000_0000_0000;
  localparam logic signed [63:0] ROUND_BIAS = 64'sh0000_0001_0000_0000;
  localparam logic signed [15:0] OUT_MAX    = 16'sh7fff;
  localparam logic signed [15:0] OUT_MIN    = -16'sh8000;

  typedef logic signed [OFS_W-1:0] ofs_t;
  typedef logic signed [OFS_W:0]   dot_t;
  typedef logic signed [52:0]      contrib_t;
  typedef logic [3:0]              grad_t;

  localparam logic [7:0] PERM_ROM [256] = '{
    8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
    8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
    8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
    8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
    8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
    8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
    8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,
    8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
    8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,
    8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
    8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,
    8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
    8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
    8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
    8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,
    8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
    8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,
    8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
    8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,
    8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
    8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
    8'd215,8'd61,8'd156,8'd180
  };

  // permutation entry modulo 12, quotient by reciprocal 171/2048
  function automatic grad_t perm_mod12(input logic [7:0] idx);
    logic [7:0]  v;
    logic [15:0] prod;
    logic [4:0]  q;
    logic [7:0]  rem;
    v    = PERM_ROM[idx];
    prod = 16'(v) * 16'd171;
    q    = prod[15:11];
    rem  = v - 8'(q) * 8'd12;
    return rem[3:0];
  endfunction

  // gradient dot product for the edge gradients that perm_mod12 selects
  function automatic dot_t grad_dot(input grad_t g, input ofs_t dx, input ofs_t dy);
    dot_t ex;
    dot_t ey;
    dot_t res;
    ex = dot_t'(dx);
    ey = dot_t'(dy);
    case (g)
      4'd0:    res = ex + ey;
      4'd1:    res = ey - ex;
      4'd2:    res = ex - ey;
      4'd3:    res = -ex - ey;
      4'd4:    res = ex;
      4'd5:    res = -ex;
      4'd6:    res = ex;
      4'd7:    res = -ex;
      4'd8:    res = ey;
      4'd9:    res = -ey;
      4'd10:   res = ey;
      4'd11:   res = -ey;
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage

FILE: design/sn2d_corner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sn2d_corner
// Five-stage pipeline for one simplex corner: radial falloff to the fourth
// power times the gradient dot product, Q.48.
// ----------------------------------------------------------------------------
module sn2d_corner
  import sn2d_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  ofs_t     dx,
  input  ofs_t     dy,
  input  grad_t    grad,
  output logic     out_valid,
  output contrib_t contrib
);

  logic [4:0]        vld_r;
  logic [53:0]       sqx_r, sqy_r;
  dot_t              dot1_r, dot2_r, dot3_r, dot4_r;
  logic signed [55:0] r_nxt;
  logic [23:0]       t_r, t_nxt;
  logic [47:0]       tt_prod, t4_prod;
  logic [23:0]       t2_r, t4_r;
  contrib_t          contrib_r, contrib_nxt;

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[3:0], in_valid};
    end
  end

  // squares and gradient dot
  always_ff @(posedge clk) begin
    sqx_r  <= 54'($signed(dx) * $signed(dx));
    sqy_r  <= 54'($signed(dy) * $signed(dy));
    dot1_r <= grad_dot(grad, dx, dy);
  end

  // falloff base, zero for a far corner
  always_comb begin
    r_nxt = HALF_Q48 - $signed({2'b00, sqx_r}) - $signed({2'b00, sqy_r});
    t_nxt = r_nxt[55] ? 24'd0 : r_nxt[47:24];
  end

  always_ff @(posedge clk) begin
    t_r    <= t_nxt;
    dot2_r <= dot1_r;
  end

  // second and fourth powers
  assign tt_prod = t_r * t_r;
  assign t4_prod = t2_r * t2_r;

  always_ff @(posedge clk) begin
    t2_r   <= tt_prod[47:24];
    dot3_r <= dot2_r;
    t4_r   <= t4_prod[47:24];
    dot4_r <= dot3_r;
  end

  // weighted contribution
  assign contrib_nxt = contrib_t'($signed({1'b0, t4_r}) * dot4_r);

  always_ff @(posedge clk) begin
    contrib_r <= contrib_nxt;
  end

  assign out_valid = vld_r[4];
  assign contrib   = contrib_r;

endmodule

FILE: design/simplex_noise_2d_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// simplex_noise_2d_unit
// 2D simplex noise: Q16.16 sample point in, Q1.15 noise value out.
// ----------------------------------------------------------------------------
// pipeline: a beat passes stages a to e, the corner pipelines, the corner sum
//   register and the output register, in that order
// throughput: one beat per cycle; busy is never raised, the pipeline only
//   moves forward and the receiver cannot stall
// reset: synchronous active-low rst_n clears all valid bits; no table to clear
module simplex_noise_2d_unit
  import sn2d_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_coord_x,
  input  logic signed [31:0] in_coord_y,
  output logic               out_valid,
  output logic signed [15:0] out_noise_value
);

  logic accept;

  // stage a: input register
  logic               a_valid_r;
  logic [XS_W-1:0]    a_x_r, a_y_r;
  logic signed [32:0] a_sum_r;
  // stage b: skew product
  logic               b_valid_r;
  logic [XS_W-1:0]    b_x_r, b_y_r;
  logic signed [63:0] b_prod_r;
  // stage c: cell and fraction
  logic               c_valid_r;
  logic [XS_W-1:0]    xs_nxt, ys_nxt;
  logic [23:0]        c_fx_r, c_fy_r;
  logic [24:0]        c_fsum_r;
  logic [7:0]         c_ii_r, c_p0_r, c_p1_r;
  // stage d: unskew product and hashes
  logic               d_valid_r;
  logic [23:0]        d_fx_r, d_fy_r;
  logic [54:0]        d_uprod_r;
  grad_t              d_h00_r, d_h10_r, d_h01_r, d_h11_r;
  // stage e: corner offsets
  logic               e_valid_r;
  ofs_t               x0_nxt, y0_nxt;
  logic               i1_nxt;
  ofs_t               e_dx_r [3];
  ofs_t               e_dy_r [3];
  grad_t              e_g_r  [3];
  // corners and output
  logic [2:0]         c_vld;
  contrib_t           c_contrib [3];
  logic               s_valid_r;
  logic signed [54:0] s_sum_r;
  logic signed [63:0] scaled;
  logic signed [63:0] q;
  logic signed [15:0] sat_nxt;
  logic               out_valid_r;
  logic signed [15:0] out_noise_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // valid bits of the front stages, the corner sum and the output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      d_valid_r   <= 1'b0;
      e_valid_r   <= 1'b0;
      s_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_valid_r   <= accept;
      b_valid_r   <= a_valid_r;
      c_valid_r   <= b_valid_r;
      d_valid_r   <= c_valid_r;
      e_valid_r   <= d_valid_r;
      s_valid_r   <= c_vld[0];
      out_valid_r <= s_valid_r;
    end
  end

  // input beat, only low bits of x and y matter after skew
  always_ff @(posedge clk) begin
    a_x_r   <= in_coord_x[XS_W-1:0];
    a_y_r   <= in_coord_y[XS_W-1:0];
    a_sum_r <= 33'(in_coord_x) + 33'(in_coord_y);
  end

  // skew factor product
  always_ff @(posedge clk) begin
    b_x_r    <= a_x_r;
    b_y_r    <= a_y_r;
    b_prod_r <= $signed(a_sum_r) * $signed({1'b0, SKEW_Q32});
  end

  // skewed coordinates: lattice index and fraction
  assign xs_nxt = b_x_r + b_prod_r[32 +: XS_W];
  assign ys_nxt = b_y_r + b_prod_r[32 +: XS_W];

  always_ff @(posedge clk) begin
    c_fx_r   <= 24'(xs_nxt[INPUT_FRAC_BITS-1:0]) << (OFS_FRAC - INPUT_FRAC_BITS);
    c_fy_r   <= 24'(ys_nxt[INPUT_FRAC_BITS-1:0]) << (OFS_FRAC - INPUT_FRAC_BITS);
    c_fsum_r <= 25'((24'(xs_nxt[INPUT_FRAC_BITS-1:0]) << (OFS_FRAC - INPUT_FRAC_BITS)))
              + 25'((24'(ys_nxt[INPUT_FRAC_BITS-1:0]) << (OFS_FRAC - INPUT_FRAC_BITS)));
    c_ii_r   <= xs_nxt[XS_W-1:INPUT_FRAC_BITS];
    c_p0_r   <= PERM_ROM[ys_nxt[XS_W-1:INPUT_FRAC_BITS]];
    c_p1_r   <= PERM_ROM[ys_nxt[XS_W-1:INPUT_FRAC_BITS] + 8'd1];
  end

  // unskew product and the four candidate hashes
  always_ff @(posedge clk) begin
    d_fx_r    <= c_fx_r;
    d_fy_r    <= c_fy_r;
    d_uprod_r <= 55'(c_fsum_r) * 55'(UNSKEW_Q32);
    d_h00_r   <= perm_mod12(c_ii_r + c_p0_r);
    d_h10_r   <= perm_mod12(c_ii_r + 8'd1 + c_p0_r);
    d_h01_r   <= perm_mod12(c_ii_r + c_p1_r);
    d_h11_r   <= perm_mod12(c_ii_r + 8'd1 + c_p1_r);
  end

  // first corner offset and triangle choice
  always_comb begin
    x0_nxt = ofs_t'({3'b000, d_fx_r}) - ofs_t'({4'b0000, d_uprod_r[54:32]});
    y0_nxt = ofs_t'({3'b000, d_fy_r}) - ofs_t'({4'b0000, d_uprod_r[54:32]});
    i1_nxt = (x0_nxt > y0_nxt);
  end

  always_ff @(posedge clk) begin
    e_dx_r[0] <= x0_nxt;
    e_dy_r[0] <= y0_nxt;
    e_g_r[0]  <= d_h00_r;
    e_dx_r[1] <= x0_nxt - (i1_nxt ? ONE_Q24 : '0) + UNSKEW_Q24;
    e_dy_r[1] <= y0_nxt - (i1_nxt ? '0 : ONE_Q24) + UNSKEW_Q24;
    e_g_r[1]  <= i1_nxt ? d_h10_r : d_h01_r;
    e_dx_r[2] <= x0_nxt - ONE_Q24 + UNSKEW2_Q24;
    e_dy_r[2] <= y0_nxt - ONE_Q24 + UNSKEW2_Q24;
    e_g_r[2]  <= d_h11_r;
  end

  // three corner pipelines
  for (genvar k = 0; k < 3; k++) begin : g_corner
    sn2d_corner u_corner (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (e_valid_r),
      .dx        (e_dx_r[k]),
      .dy        (e_dy_r[k]),
      .grad      (e_g_r[k]),
      .out_valid (c_vld[k]),
      .contrib   (c_contrib[k])
    );
  end

  // corner sum
  always_ff @(posedge clk) begin
    s_sum_r <= 55'(c_contrib[0]) + 55'(c_contrib[1]) + 55'(c_contrib[2]);
  end

  // scale by 70, round half up, saturate
  always_comb begin
    scaled = (64'(s_sum_r) <<< 6) + (64'(s_sum_r) <<< 2) + (64'(s_sum_r) <<< 1);
    q      = (scaled + ROUND_BIAS) >>> 33;
    if (q > 64'(OUT_MAX)) begin
      sat_nxt = OUT_MAX;
    end else if (q < 64'(OUT_MIN)) begin
      sat_nxt = OUT_MIN;
    end else begin
      sat_nxt = q[15:0];
    end
  end

  always_ff @(posedge clk) begin
    out_noise_r <= sat_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_noise_value = out_noise_r;

  // checks
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> a_valid_r)
    else $error("accepted beat did not enter the pipeline");

  a_corners_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (c_vld[0] == c_vld[1]) && (c_vld[1] == c_vld[2]))
    else $error("corner pipelines out of step");

  a_out_follows_front: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(e_valid_r, 7))
    else $error("result strobe without a matching beat");

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for simplex_noise_2d_unit: a fixed-point noise
// predictor computes each expected sample value, a monitor compares results.
// ----------------------------------------------------------------------------
module tb;
  import sn2d_pkg::*;

  localparam int TIMEOUT_CYCLES = 2000;
  localparam int DRAIN_CYCLES   = 20;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [31:0] in_coord_x;
  logic signed [31:0] in_coord_y;
  logic               out_valid;
  logic signed [15:0] out_noise_value;

  logic signed [15:0] noise_q[$];
  int                 mismatches;
  int                 sent_beats;
  int                 checked_beats;
  int                 idle_cycles;
  int                 sat_hits;
  int                 burst_left;

  simplex_noise_2d_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_coord_x      (in_coord_x),
    .in_coord_y      (in_coord_y),
    .out_valid       (out_valid),
    .out_noise_value (out_noise_value)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // permutation lookup folded modulo 12
  function automatic int lattice_grad(input int a, input int b);
    int h;
    h = PERM_ROM[(a + PERM_ROM[b & 255]) & 255];
    return h % 12;
  endfunction

  // falloff-weighted gradient contribution of one corner, Q.48
  function automatic longint corner_term(input longint dx, input longint dy, input int g);
    longint r;
    longint t;
    longint gx;
    longint gy;
    r = (64'sd1 <<< 47) - dx * dx - dy * dy;
    if (r < 0) return 0;
    gx = (g < 8) ? ((g % 2 == 0) ? 1 : -1) : 0;
    gy = (g < 4) ? ((g < 2) ? 1 : -1) : (g < 8) ? 0 : ((g % 2 == 0) ? 1 : -1);
    t = r >>> 24;
    t = (t * t) >>> 24;
    t = (t * t) >>> 24;
    return t * (gx * dx + gy * dy);
  endfunction

  // full noise sample, Q1.15 saturated
  function automatic logic signed [15:0] noise_sample(input logic signed [31:0] cx,
                                                     input logic signed [31:0] cy);
    longint x, y, s, xs, ys, ci, cj, fx, fy, u, x0, y0, x1, y1, x2, y2, sum, q;
    longint one;
    int i1, j1, ii, jj;
    logic [127:0] wide;
    one = 64'sd1 <<< OFS_FRAC;
    x = cx;
    y = cy;
    s = ((x + y) * 64'sd1572067139) >>> 32;
    xs = x + s;
    ys = y + s;
    ci = xs >>> INPUT_FRAC_BITS;
    cj = ys >>> INPUT_FRAC_BITS;
    fx = (xs & ((64'sd1 <<< INPUT_FRAC_BITS) - 1)) <<< (OFS_FRAC - INPUT_FRAC_BITS);
    fy = (ys & ((64'sd1 <<< INPUT_FRAC_BITS) - 1)) <<< (OFS_FRAC - INPUT_FRAC_BITS);
    wide = 128'(fx + fy) * 128'd907633386;
    u = longint'(wide[95:32]);
    x0 = fx - u;
    y0 = fy - u;
    i1 = (x0 > y0) ? 1 : 0;
    j1 = 1 - i1;
    x1 = x0 - i1 * one + 3545443;
    y1 = y0 - j1 * one + 3545443;
    x2 = x0 - one + 2 * 3545443;
    y2 = y0 - one + 2 * 3545443;
    ii = int'(ci & 255);
    jj = int'(cj & 255);
    sum = corner_term(x0, y0, lattice_grad(ii, jj));
    sum += corner_term(x1, y1, lattice_grad(ii + i1, jj + j1));
    sum += corner_term(x2, y2, lattice_grad(ii + 1, jj + 1));
    q = (sum * 70 + (64'sd1 <<< 32)) >>> 33;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return 16'(q);
  endfunction

  // send one beat, idling between bursts; called and returns at a rising edge
  task automatic send_point(input logic signed [31:0] cx, input logic signed [31:0] cy);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    start      <= 1'b1;
    in_coord_x <= cx;
    in_coord_y <= cy;
    noise_q = {noise_q, noise_sample(cx, cy)};
    sent_beats++;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // result monitor and watchdog
  always @(posedge clk) begin
    logic signed [15:0] exp_v;
    if (rst_n && out_valid) begin
      if (noise_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d", out_noise_value);
      end else begin
        exp_v = noise_q.pop_front();
        checked_beats++;
        if (exp_v == 16'sh7fff || exp_v == -16'sh8000) sat_hits++;
        if (out_noise_value !== exp_v) begin
          mismatches++;
          if (mismatches <= 10)
            $display("noise mismatch: expected %0d actual %0d", exp_v, out_noise_value);
        end
      end
    end
    if (rst_n && !(start && !busy) && !out_valid) idle_cycles++;
    else idle_cycles = 0;
    if (idle_cycles >= TIMEOUT_CYCLES) begin
      $display("watchdog expired");
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // lattice corners, extremes and integer points
  task automatic test_extremes();
    send_point(32'sh0, 32'sh0);
    send_point(32'sh7fffffff, 32'sh7fffffff);
    send_point(-32'sh80000000, -32'sh80000000);
    send_point(32'sh7fffffff, -32'sh80000000);
    send_point(-32'sh80000000, 32'sh7fffffff);
    send_point(32'sh0001_0000, 32'sh0);
    send_point(32'sh0, 32'sh0001_0000);
    send_point(-32'sh1, -32'sh1);
    send_point(32'shffff_ffff, 32'sh0);
    send_point(32'sh5555_5555, 32'shaaaa_aaaa);
  endtask

  // diagonal ties, wrap by 256 units, near-cell-center saturation probes
  task automatic test_special();
    int k;
    for (k = 0; k < 4; k++) send_point(32'(k * 12345), 32'(k * 12345));
    send_point(32'sh0100_8000, 32'sh0000_8000);
    send_point(32'sh0000_8000, 32'sh0000_8000);
    send_point(32'sh0000_4c00, 32'sh0000_2300);
    send_point(32'sh0000_2300, 32'sh0000_4c00);
    send_point(32'sh0000_b400, 32'sh0000_dd00);
    send_point(32'sh1000_4000, 32'shf000_4000);
  endtask

  // random sample points: half small-range, half full-range (half of those near the diagonal)
  task automatic test_random(input int n);
    logic signed [31:0] cx, cy;
    repeat (n) begin
      case ($urandom_range(0, 3))
        0: begin cx = $urandom; cy = $urandom; end
        1: begin cx = $urandom; cy = cx + $urandom_range(0, 3) - 1; end
        default: begin
          cx = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
          cy = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
        end
      endcase
      send_point(cx, cy);
    end
  endtask

  initial begin
    int wait_cycles;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_coord_x  = '0;
    in_coord_y  = '0;
    mismatches  = 0;
    sent_beats  = 0;
    checked_beats = 0;
    idle_cycles = 0;
    sat_hits    = 0;
    burst_left  = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_extremes();
    test_special();
    test_random(1130);
    start <= 1'b0;
    wait_cycles = 0;
    while (noise_q.size() != 0 && wait_cycles < TIMEOUT_CYCLES) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d sample points, %0d results checked, %0d saturated",
             sent_beats, checked_beats, sat_hits);
    if (mismatches == 0 && noise_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, noise_q.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
